// ===== rtl/bpic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpic_pkg
// Shared beat types, register map and reset values of the clamped body
// position integrator.
// ----------------------------------------------------------------------------
package bpic_pkg;

    localparam int TS_W  = 17;
    localparam int MT_W  = 31;
    localparam int MR_W  = 18;
    localparam int ADDR_W = 4;

    localparam logic [TS_W-1:0] TS_RESET = 17'd1092;
    localparam logic [MT_W-1:0] MT_RESET = 31'd131072;
    localparam logic [MR_W-1:0] MR_RESET = 18'd102944;

    typedef enum logic [1:0] {
        REG_TIME_STEP = 2'd0,
        REG_MAX_TRANS = 2'd1,
        REG_MAX_ROT   = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] angle_in;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_angle;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_spin;
    } out_beat_t;

endpackage
`default_nettype wire

// ===== rtl/body_position_integrator_clamped_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// body_position_integrator_clamped_core
// Clamps one body's linear and angular velocity to the per-step limits and
// advances its position and angle by one time step, saturating.
// ----------------------------------------------------------------------------
// Usage:
// A body enters as one beat on the item channel (item_valid / item_ready)
// and its result leaves as one beat on the result channel (result_valid /
// result_ready). Registers are to be written over the APB port only while
// idle; the block itself does not enforce this. The pipeline takes one body
// per cycle while the output is not stalled. The depth comes from the
// 32-stage square root of the squared step translation and the bit-per-stage
// divisions that rescale the velocity.
// All stages advance together; when the result register holds a beat that
// the receiver does not take, the whole pipeline and item_ready hold, and
// nothing is dropped or repeated. Reset empties the pipeline and restores
// the registers to their reset values.
// ----------------------------------------------------------------------------
module body_position_integrator_clamped_core #(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire bpic_pkg::in_beat_t              item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output bpic_pkg::out_beat_t                  result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bpic_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import bpic_pkg::*;

    localparam int PW   = 32 + TS_W;
    localparam int TW   = 32 + TS_W - 1 - FRAC_BITS;
    localparam int SMAX = (TW > 31) ? TW - 31 : 0;
    localparam int SW   = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
    localparam int QW   = 32 + SMAX;
    localparam int AW   = ((TW > 32) ? TW : 32) + 2;
    localparam int PXW  = 32 + MT_W;
    localparam int PWW  = 32 + MR_W;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] angle;
        logic        neg_x;
        logic        neg_y;
        logic        neg_w;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] aw;
    } base_t;

    typedef struct packed {
        base_t            base;
        logic [SW-1:0]    s;
        logic             over;
        logic             rot_over;
        logic [PXW-1:0]   pmx;
        logic [PXW-1:0]   pmy;
        logic [PWW-1:0]   pmw;
        logic [TW-1:0]    r;
    } sq_side_t;

    typedef struct packed {
        base_t            base;
        logic [SW-1:0]    s;
        logic             over;
        logic             rot_over;
    } dv_side_t;

    // Configuration registers.
    logic [TS_W-1:0] ts_reg;
    logic [MT_W-1:0] mt_reg;
    logic [MR_W-1:0] mr_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= TS_RESET;
            mt_reg <= MT_RESET;
            mr_reg <= MR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_reg_e'(paddr[3:2]))
                REG_TIME_STEP: ts_reg <= pwdata[TS_W-1:0];
                REG_MAX_TRANS: mt_reg <= pwdata[MT_W-1:0];
                REG_MAX_ROT:   mr_reg <= pwdata[MR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_e'(paddr[3:2]))
            REG_TIME_STEP: prdata = 32'(ts_reg);
            REG_MAX_TRANS: prdata = 32'(mt_reg);
            REG_MAX_ROT:   prdata = 32'(mr_reg);
            default:       prdata = '0;
        endcase
    end

    // All stages move together unless a finished beat waits at the output.
    logic adv;
    logic out_valid_reg;

    assign adv        = !out_valid_reg || result_ready;
    assign item_ready = adv;

    // Stage 1: magnitudes and signs.
    base_t s1_next;
    base_t s1_reg;
    logic  s1_valid_reg;

    always_comb
    begin
        s1_next.pos_x = item.pos_x;
        s1_next.pos_y = item.pos_y;
        s1_next.angle = item.angle_in;
        s1_next.neg_x = item.vel_x[31];
        s1_next.neg_y = item.vel_y[31];
        s1_next.neg_w = item.spin[31];
        s1_next.ax    = item.vel_x[31] ? (~item.vel_x + 32'd1) : item.vel_x;
        s1_next.ay    = item.vel_y[31] ? (~item.vel_y + 32'd1) : item.vel_y;
        s1_next.aw    = item.spin[31]  ? (~item.spin + 32'd1)  : item.spin;
    end

    // Stage 2: step translation and rotation.
    base_t         s2_reg;
    logic          s2_valid_reg;
    logic [TW-1:0] tx_reg;
    logic [TW-1:0] ty_reg;
    logic [TW-1:0] r2_reg;
    logic [PW-1:0] ptx;
    logic [PW-1:0] pty;
    logic [PW-1:0] ptw;

    assign ptx = PW'(s1_reg.ax) * PW'(ts_reg);
    assign pty = PW'(s1_reg.ay) * PW'(ts_reg);
    assign ptw = PW'(s1_reg.aw) * PW'(ts_reg);

    // Stage 3: range reduction shift and numerator products.
    sq_side_t      s3_next;
    sq_side_t      s3_reg;
    logic          s3_valid_reg;
    logic [30:0]   a_reg;
    logic [30:0]   b_reg;
    logic [TW-1:0] m_max;
    logic [SW-1:0] s_sel;

    always_comb
    begin
        logic found;
        found = 1'b0;
        s_sel = '0;
        m_max = (tx_reg > ty_reg) ? tx_reg : ty_reg;
        for (int k = 0; k <= SMAX; k++)
        begin
            if (!found && (((m_max >> k) >> 31) == '0))
            begin
                s_sel = SW'(k);
                found = 1'b1;
            end
        end
        s3_next.base     = s2_reg;
        s3_next.s        = s_sel;
        s3_next.over     = AW'(m_max) > AW'(mt_reg);
        s3_next.rot_over = r2_reg > TW'(mr_reg);
        s3_next.pmx      = PXW'(s2_reg.ax) * PXW'(mt_reg);
        s3_next.pmy      = PXW'(s2_reg.ay) * PXW'(mt_reg);
        s3_next.pmw      = PWW'(s2_reg.aw) * PWW'(mr_reg);
        s3_next.r        = r2_reg;
    end

    // Stage 4: squares.
    sq_side_t    s4_reg;
    logic        s4_valid_reg;
    logic [61:0] sqa_reg;
    logic [61:0] sqb_reg;
    logic [61:0] mt2_reg;

    // Stage 5: squared length and final over-limit decision.
    sq_side_t    s5_next;
    sq_side_t    s5_reg;
    logic        s5_valid_reg;
    logic [62:0] sum_next;
    logic [62:0] sum_reg;

    always_comb
    begin
        sum_next     = {1'b0, sqa_reg} + {1'b0, sqb_reg};
        s5_next      = s4_reg;
        s5_next.over = s4_reg.over || (sum_next > {1'b0, mt2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s1_reg;
            tx_reg  <= TW'(ptx >> FRAC_BITS);
            ty_reg  <= TW'(pty >> FRAC_BITS);
            r2_reg  <= TW'(ptw >> FRAC_BITS);
            s3_reg  <= s3_next;
            a_reg   <= 31'(tx_reg >> s_sel);
            b_reg   <= 31'(ty_reg >> s_sel);
            s4_reg  <= s3_reg;
            sqa_reg <= 62'(a_reg) * 62'(a_reg);
            sqb_reg <= 62'(b_reg) * 62'(b_reg);
            mt2_reg <= 62'(mt_reg) * 62'(mt_reg);
            s5_reg  <= s5_next;
            sum_reg <= sum_next;
        end
    end

    // Square root of the reduced squared translation length.
    logic [31:0] len;
    sq_side_t    sq_side_reg  [0:31];
    logic        sq_valid_reg [0:31];

    bpic_isqrt_pipe u_isqrt
    (
        .clk      (clk),
        .en       (adv),
        .radicand ({1'b0, sum_reg}),
        .root     (len)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= s5_reg;
            for (int k = 1; k < 32; k++)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    // Divisions that rescale the velocity and the spin.
    sq_side_t    sq_out;
    logic [31:0] len_safe;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic [QW-1:0] qw;
    dv_side_t    dv_side_next;
    dv_side_t    dv_side_reg  [0:QW-1];
    logic        dv_valid_reg [0:QW-1];

    assign sq_out   = sq_side_reg[31];
    assign len_safe = (len == '0) ? 32'd1 : len;

    always_comb
    begin
        dv_side_next.base     = sq_out.base;
        dv_side_next.s        = sq_out.s;
        dv_side_next.over     = sq_out.over;
        dv_side_next.rot_over = sq_out.rot_over;
    end

    bpic_div_pipe #(.DW(PXW), .VW(32), .QW(QW)) u_div_x
    (
        .clk      (clk),
        .en       (adv),
        .dividend (sq_out.pmx),
        .divisor  (len_safe),
        .quotient (qx)
    );

    bpic_div_pipe #(.DW(PXW), .VW(32), .QW(QW)) u_div_y
    (
        .clk      (clk),
        .en       (adv),
        .dividend (sq_out.pmy),
        .divisor  (len_safe),
        .quotient (qy)
    );

    bpic_div_pipe #(.DW(PWW), .VW(TW), .QW(QW)) u_div_w
    (
        .clk      (clk),
        .en       (adv),
        .dividend (sq_out.pmw),
        .divisor  (sq_out.r),
        .quotient (qw)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= dv_side_next;
            for (int k = 1; k < QW; k++)
            begin
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end
    end

    // Select clamped magnitudes and form the position deltas.
    dv_side_t      dv_out;
    logic [31:0]   magx_next;
    logic [31:0]   magy_next;
    logic [31:0]   magw_next;
    logic [PW-1:0] pdx;
    logic [PW-1:0] pdy;
    logic [PW-1:0] pdw;
    base_t         x_base_reg;
    logic          x_valid_reg;
    logic          x_over_reg;
    logic          x_rot_reg;
    logic [31:0]   x_magx_reg;
    logic [31:0]   x_magy_reg;
    logic [31:0]   x_magw_reg;
    logic [TW-1:0] x_dx_reg;
    logic [TW-1:0] x_dy_reg;
    logic [TW-1:0] x_dw_reg;

    assign dv_out    = dv_side_reg[QW-1];
    assign magx_next = dv_out.over ? 32'(qx >> dv_out.s) : dv_out.base.ax;
    assign magy_next = dv_out.over ? 32'(qy >> dv_out.s) : dv_out.base.ay;
    assign magw_next = dv_out.rot_over ? 32'(qw) : dv_out.base.aw;
    assign pdx       = PW'(magx_next) * PW'(ts_reg);
    assign pdy       = PW'(magy_next) * PW'(ts_reg);
    assign pdw       = PW'(magw_next) * PW'(ts_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_base_reg <= dv_out.base;
            x_over_reg <= dv_out.over;
            x_rot_reg  <= dv_out.rot_over;
            x_magx_reg <= magx_next;
            x_magy_reg <= magy_next;
            x_magw_reg <= magw_next;
            x_dx_reg   <= TW'(pdx >> FRAC_BITS);
            x_dy_reg   <= TW'(pdy >> FRAC_BITS);
            x_dw_reg   <= TW'(pdw >> FRAC_BITS);
        end
    end

    // Output stage: saturating add and signed velocities.
    function automatic logic [31:0] sat_add(logic [31:0] base_val, logic neg,
                                            logic [TW-1:0] delta);
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] d;
        d   = $signed(AW'(delta));
        acc = $signed(AW'($signed(base_val))) + (neg ? -d : d);
        if (acc > $signed(AW'(32'h7FFF_FFFF)))
        begin
            return 32'h7FFF_FFFF;
        end
        else if (acc < -$signed(AW'(33'h0_8000_0000)))
        begin
            return 32'h8000_0000;
        end
        return acc[31:0];
    endfunction

    out_beat_t result_next;
    out_beat_t result_reg;

    always_comb
    begin
        result_next.new_pos_x = sat_add(x_base_reg.pos_x, x_base_reg.neg_x, x_dx_reg);
        result_next.new_pos_y = sat_add(x_base_reg.pos_y, x_base_reg.neg_y, x_dy_reg);
        result_next.new_angle = sat_add(x_base_reg.angle, x_base_reg.neg_w, x_dw_reg);
        result_next.new_vel_x = x_base_reg.neg_x ? (~x_magx_reg + 32'd1) : x_magx_reg;
        result_next.new_vel_y = x_base_reg.neg_y ? (~x_magy_reg + 32'd1) : x_magy_reg;
        result_next.new_spin  = x_base_reg.neg_w ? (~x_magw_reg + 32'd1) : x_magw_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    // Valid bits travel with the data and are the only pipeline state reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            for (int k = 0; k < 32; k++)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k < QW; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= item_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            sq_valid_reg[0] <= s5_valid_reg;
            for (int k = 1; k < 32; k++)
            begin
                sq_valid_reg[k] <= sq_valid_reg[k-1];
            end
            dv_valid_reg[0] <= sq_valid_reg[31];
            for (int k = 1; k < QW; k++)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
            x_valid_reg   <= dv_valid_reg[QW-1];
            out_valid_reg <= x_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // A clamped velocity never grows beyond the incoming magnitude.
    a_clamp_trans: assert property (@(posedge clk) disable iff (!rst_n)
        (x_valid_reg && x_over_reg) |->
        (x_magx_reg <= x_base_reg.ax && x_magy_reg <= x_base_reg.ay))
        else $error("clamped linear velocity exceeds input magnitude");

    a_clamp_rot: assert property (@(posedge clk) disable iff (!rst_n)
        (x_valid_reg && x_rot_reg) |-> (x_magw_reg <= x_base_reg.aw))
        else $error("clamped spin exceeds input magnitude");

    // An over-limit translation always has a nonzero length to divide by.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_valid_reg[31] && sq_out.over) |-> (len != '0))
        else $error("zero translation length on the clamping path");

endmodule
`default_nettype wire

// ===== rtl/bpic_isqrt_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpic_isqrt_pipe
// Pipelined integer square root of a 64-bit radicand, one result bit per
// stage over 32 stages.
// ----------------------------------------------------------------------------
module bpic_isqrt_pipe
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root
);
    logic [63:0] n_reg [0:31];
    logic [63:0] r_reg [0:31];

    genvar k;
    generate
        for (k = 0; k < 32; k++)
        begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic [63:0] n_in;
            logic [63:0] r_in;
            logic [63:0] trial;
            logic [63:0] n_next;
            logic [63:0] r_next;

            if (k == 0)
            begin : g_first
                assign n_in = radicand;
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign n_in = n_reg[k-1];
                assign r_in = r_reg[k-1];
            end

            always_comb
            begin
                trial = r_in + BIT;
                if (n_in >= trial)
                begin
                    n_next = n_in - trial;
                    r_next = (r_in >> 1) + BIT;
                end
                else
                begin
                    n_next = n_in;
                    r_next = r_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k] <= n_next;
                    r_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    assign root = r_reg[31][31:0];

endmodule
`default_nettype wire

// ===== rtl/bpic_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpic_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The quotient
// must fit in QW bits, so the top dividend bits start as the remainder.
// ----------------------------------------------------------------------------
module bpic_div_pipe #(
    parameter int DW = 63,
    parameter int VW = 32,
    parameter int QW = 33
)
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic      [QW-1:0] quotient
);
    logic [VW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] lo_reg  [0:QW-1];
    logic [VW-1:0] dvs_reg [0:QW-1];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [VW-1:0] rem_in;
            logic [QW-1:0] lo_in;
            logic [VW-1:0] dvs_in;
            logic [VW:0]   trial;
            logic          ge;
            logic [VW-1:0] rem_next;
            logic [QW-1:0] lo_next;

            if (k == 0)
            begin : g_first
                assign rem_in = VW'(dividend[DW-1:QW]);
                assign lo_in  = dividend[QW-1:0];
                assign dvs_in = divisor;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign lo_in  = lo_reg[k-1];
                assign dvs_in = dvs_reg[k-1];
            end

            always_comb
            begin
                trial    = {rem_in, lo_in[QW-1]};
                ge       = trial >= {1'b0, dvs_in};
                rem_next = ge ? VW'(trial - {1'b0, dvs_in}) : VW'(trial);
                lo_next  = {lo_in[QW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    lo_reg[k]  <= lo_next;
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    endgenerate

    assign quotient = lo_reg[QW-1];

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives bodies through the clamped position integrator under random
// back-pressure and compares every result beat with a local predictor.
// ----------------------------------------------------------------------------
module tb;
    import bpic_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 72;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    in_beat_t item;
    logic result_valid;
    logic result_ready;
    out_beat_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    body_position_integrator_clamped_core #(.FRAC_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Predictor copy of the registers.
    logic [63:0] step_h;
    logic [63:0] trans_lim;
    logic [63:0] rot_lim;

    out_beat_t pending_bodies[$];
    int errors;
    longint cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_recv;

    typedef struct {
        in_beat_t body;
        bit has_exp;
        out_beat_t exp_beat;
    } stim_row_t;

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] absval(logic signed [31:0] v);
        logic signed [63:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic signed [31:0] signed_of(bit neg, logic [63:0] m);
        logic signed [63:0] w;
        w = neg ? -$signed(m) : $signed(m);
        return w[31:0];
    endfunction

    function automatic logic signed [31:0] advance(logic signed [31:0] p, bit neg,
                                                   logic [63:0] m);
        logic signed [63:0] s;
        s = $signed({{32{p[31]}}, p}) + (neg ? -$signed(m) : $signed(m));
        if (s > 64'sd2147483647)
            return 32'sh7fffffff;
        if (s < -64'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic out_beat_t integrate_body(in_beat_t b);
        out_beat_t o;
        logic [63:0] ax, ay, aw, tx, ty, mx, a, c, len, r;
        logic signed [31:0] vx, vy, w;
        int s;
        vx = b.vel_x;
        vy = b.vel_y;
        w = b.spin;
        ax = absval(vx);
        ay = absval(vy);
        aw = absval(w);
        tx = (ax * step_h) >> FB;
        ty = (ay * step_h) >> FB;
        mx = (tx > ty) ? tx : ty;
        if (mx > trans_lim || tx * tx + ty * ty > trans_lim * trans_lim)
        begin
            s = 0;
            while ((mx >> s) >= (64'd1 << 31))
                s++;
            a = tx >> s;
            c = ty >> s;
            len = root64(a * a + c * c);
            if (len == 0)
                len = 1;
            ax = ((ax * trans_lim) / len) >> s;
            ay = ((ay * trans_lim) / len) >> s;
            vx = signed_of(vx < 0, ax);
            vy = signed_of(vy < 0, ay);
        end
        r = (aw * step_h) >> FB;
        if (r > rot_lim)
        begin
            aw = (aw * rot_lim) / r;
            w = signed_of(w < 0, aw);
        end
        o.new_pos_x = advance(b.pos_x, vx < 0, (ax * step_h) >> FB);
        o.new_pos_y = advance(b.pos_y, vy < 0, (ay * step_h) >> FB);
        o.new_angle = advance(b.angle_in, w < 0, (aw * step_h) >> FB);
        o.new_vel_x = vx;
        o.new_vel_y = vy;
        o.new_spin = w;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver side and checker.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_bodies.size() == 0)
            begin
                report_mismatch("unexpected beat", result.new_pos_x, 32'h0);
            end
            else
            begin
                want = pending_bodies.pop_front();
                if (result.new_pos_x !== want.new_pos_x)
                    report_mismatch("new_pos_x", result.new_pos_x, want.new_pos_x);
                if (result.new_pos_y !== want.new_pos_y)
                    report_mismatch("new_pos_y", result.new_pos_y, want.new_pos_y);
                if (result.new_angle !== want.new_angle)
                    report_mismatch("new_angle", result.new_angle, want.new_angle);
                if (result.new_vel_x !== want.new_vel_x)
                    report_mismatch("new_vel_x", result.new_vel_x, want.new_vel_x);
                if (result.new_vel_y !== want.new_vel_y)
                    report_mismatch("new_vel_y", result.new_vel_y, want.new_vel_y);
                if (result.new_spin !== want.new_spin)
                    report_mismatch("new_spin", result.new_spin, want.new_spin);
            end
        end
        result_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TIME_STEP: step_h = val & 32'h1ffff;
            REG_MAX_TRANS: trans_lim = val & 32'h7fffffff;
            default: rot_lim = val & 32'h3ffff;
        endcase
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_bodies.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // One body beat; the prediction is queued when the beat is taken.
    // Valid drops only while the sender idles or waits for the drain.
    task automatic send_body(in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_bodies.push_back(integrate_body(b));
    endtask

    function automatic logic signed [31:0] rand_field(int velocity);
        case ($urandom_range(velocity ? 5 : 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            4: return $signed($urandom_range(2000)) - 1000;
            default: return $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
        endcase
    endfunction

    function automatic in_beat_t rand_body();
        in_beat_t b;
        b.pos_x = rand_field(0);
        b.pos_y = rand_field(0);
        b.angle_in = rand_field(0);
        b.vel_x = rand_field(1);
        b.vel_y = rand_field(1);
        b.spin = rand_field(1);
        return b;
    endfunction

    function automatic stim_row_t row(in_beat_t b, bit has, out_beat_t e);
        stim_row_t t;
        t.body = b;
        t.has_exp = has;
        t.exp_beat = e;
        return t;
    endfunction

    initial
    begin
        stim_row_t rows[$];
        in_beat_t b;
        out_beat_t e;
        logic [31:0] ts_vals[5];
        logic [31:0] mt_vals[5];
        logic [31:0] mr_vals[5];
        int phase;
        int i;

        errors = 0;
        cycles = 0;
        hold_recv = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        step_h = TS_RESET;
        trans_lim = MT_RESET;
        rot_lim = MR_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings; zero body gives zero result.
        rows.push_back(row('0, 1, '0));
        b = '0; b.pos_x = 32'sh7fffffff; b.vel_x = 32'sh00010000;
        e = '0; e.new_pos_x = 32'sh7fffffff; e.new_vel_x = 32'sh00010000;
        rows.push_back(row(b, 1, e));
        b = '0; b.pos_y = 32'sh80000000; b.vel_y = -32'sh00010000;
        e = '0; e.new_pos_y = 32'sh80000000; e.new_vel_y = -32'sh00010000;
        rows.push_back(row(b, 1, e));
        b = '0; b.vel_x = 32'sh7fffffff; b.vel_y = 32'sh80000000;
        b.spin = 32'sh7fffffff; b.angle_in = 32'sh7fffffff;
        rows.push_back(row(b, 0, e));
        b.spin = 32'sh80000000; b.angle_in = 32'sh80000000;
        rows.push_back(row(b, 0, e));
        b = '0; b.vel_x = 32'sh00400000; b.vel_y = -32'sh00300000; b.spin = 32'sh01000000;
        rows.push_back(row(b, 0, e));
        for (i = 0; i < 10; i++)
            rows.push_back(row(rand_body(), 0, e));
        foreach (rows[k])
        begin
            send_body(rows[k].body);
            if (rows[k].has_exp)
                pending_bodies[$] = rows[k].exp_beat;
        end
        wait_drained();

        // Zero step, zero limits, and the largest values of each register.
        ts_vals = '{32'd0, 32'd65536, 32'h1ffff, 32'd1092, 32'd7};
        mt_vals = '{32'd0, 32'h7fffffff, 32'd131072, 32'd1, 32'hffffffff};
        mr_vals = '{32'd0, 32'd205887, 32'h3ffff, 32'd102944, 32'd3};
        for (phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_TIME_STEP, ts_vals[phase]);
            write_reg(REG_MAX_TRANS, mt_vals[phase]);
            write_reg(REG_MAX_ROT, mr_vals[phase]);
            b = rand_body();
            send_body(b);
            wait_drained();
        end

        // Random part: three idle profiles, random registers per phase.
        for (phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 14 : (phase < 4) ? 60 : 0;
            recv_idle_pct = (phase < 2) ? 60 : (phase < 4) ? 14 : 0;
            write_reg(REG_TIME_STEP, $urandom_range(2) == 0 ? $urandom : $urandom_range(4000));
            write_reg(REG_MAX_TRANS, $urandom_range(1) ? $urandom : $urandom_range(400000));
            write_reg(REG_MAX_ROT, $urandom_range(1) ? $urandom : $urandom_range(205887));
            for (i = 0; i < 210; i++)
                send_body(rand_body());
            if (phase == 4)
            begin
                // Long receiver hold while bodies keep coming.
                fork
                    begin
                        hold_recv = 1;
                        repeat (300) @(posedge clk);
                        hold_recv = 0;
                    end
                    for (int j = 0; j < 120; j++)
                        send_body(rand_body());
                join
            end
            wait_drained();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bpic_pkg.sv
rtl/bpic_isqrt_pipe.sv
rtl/bpic_div_pipe.sv
rtl/body_position_integrator_clamped_core.sv
test/tb.sv
